// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ring RTL.
// Expect clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/pqr_pkg.sv -----
// Shared types and constants of the profiling query ring.
// No dependencies; every other file but assert_macros.svh imports this package.
package pqr_pkg;

	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int TAG_W      = 16;
	localparam int SAMPLE_W   = 32;
	localparam int NS_W       = 64;
	localparam int STAT_W     = 32;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_POLL  = 2'd2;

	typedef struct packed {
		logic [1:0]          command;
		logic [TAG_W-1:0]    label_tag;
		logic                label_present;
		logic [SAMPLE_W-1:0] sample_number;
		logic                oldest_done;
		logic [NS_W-1:0]     elapsed_ns;
	} cmd_item_t;

	typedef struct packed {
		logic                retired_valid;
		logic [TAG_W-1:0]    retired_tag;
		logic [SAMPLE_W-1:0] retired_sample;
		logic [NS_W-1:0]     retired_ns;
		logic [CNT_W-1:0]    pending_entries;
		logic                interval_open;
		logic [STAT_W-1:0]   invalid_total;
		logic [STAT_W-1:0]   dropped_total;
		logic [STAT_W-1:0]   submitted_total;
		logic [STAT_W-1:0]   completed_total;
	} res_item_t;

	// Decisions of one command, carried from the control stage to the stats stage.
	typedef struct packed {
		logic             inc_invalid;
		logic             inc_dropped;
		logic             inc_submitted;
		logic             inc_completed;
		logic             tag_check;
		logic [TAG_W-1:0] check_tag;
		logic [NS_W-1:0]  elapsed_ns;
		logic [CNT_W-1:0] pending;
		logic             open;
	} stage_t;

endpackage

// ----- hdl/pqr_cmd_if.sv -----
// Command channel: valid/ready handshake with one command item as payload.
// Depends on pqr_pkg.
interface pqr_cmd_if import pqr_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- hdl/pqr_res_if.sv -----
// Result channel: valid/ready handshake with one result item as payload.
// Depends on pqr_pkg.
interface pqr_res_if import pqr_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- hdl/profiling_query_ring.sv -----
// Profiling query ring: pending timing intervals kept in a ring of RING_DEPTH slots.
// cmd_ch takes one command per beat: begin (open an interval, store tag and
// sample number at the tail), end (close and commit it) or poll (retire the
// oldest committed entry when the source reports it done). res_ch returns
// exactly one beat per command: the retired entry if any, the fill level, the
// open flag and the invalid, dropped, submitted and completed counters.
// The control registers and the ring read port form stage 1, counters and the
// result register stage 2. One command is taken per cycle while res_ch is not
// stalled; the update of head, fill count and open slot as each command is
// taken sets that rate.
// A stalled res_ch holds its beat; stage 1 keeps one more command, then
// cmd_ch.ready drops until the result is taken.
// Reset clears the pointers, open flag, drop marker and counters and sets
// timing_enabled; ring contents are left as they are and read only after a
// begin wrote them. Write cfg_wr_en/cfg_wr_data only while the block is idle.
// Depends on pqr_pkg, pqr_cmd_if, pqr_res_if, pqr_ctrl, pqr_ring_mem, pqr_stats.
`include "assert_macros.svh"

module profiling_query_ring import pqr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	pqr_cmd_if.sink   cmd_ch,
	pqr_res_if.source res_ch
);

	logic                timing_en_q;
	logic                s1_valid_q;
	logic                out_valid_q;
	logic                advance;
	logic                accept;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [TAG_W-1:0]    wr_tag;
	logic [SAMPLE_W-1:0] wr_sample;
	logic [IDX_W-1:0]    end_addr;
	logic [IDX_W-1:0]    poll_addr;
	logic [TAG_W-1:0]    end_tag_s1;
	logic [TAG_W-1:0]    poll_tag_s1;
	logic [SAMPLE_W-1:0] poll_sample_s1;
	stage_t              stage_s1;
	res_item_t           result;

	assign advance      = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = !s1_valid_q || advance;
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign res_ch.valid = out_valid_q;
	assign res_ch.payload = result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			timing_en_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_ch.ready) begin
				s1_valid_q <= cmd_ch.valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	pqr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.item           (cmd_ch.payload),
		.timing_enabled (timing_en_q),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_tag         (wr_tag),
		.wr_sample      (wr_sample),
		.end_addr       (end_addr),
		.poll_addr      (poll_addr),
		.stage_s1       (stage_s1)
	);

	pqr_ring_mem u_mem (
		.clk            (clk),
		.rd_en          (accept),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_tag         (wr_tag),
		.wr_sample      (wr_sample),
		.end_addr       (end_addr),
		.poll_addr      (poll_addr),
		.end_tag_s1     (end_tag_s1),
		.poll_tag_s1    (poll_tag_s1),
		.poll_sample_s1 (poll_sample_s1)
	);

	pqr_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (s1_valid_q && advance),
		.stage_s1       (stage_s1),
		.end_tag_s1     (end_tag_s1),
		.poll_tag_s1    (poll_tag_s1),
		.poll_sample_s1 (poll_sample_s1),
		.result         (result)
	);

	`ASSERT_CLK(a_s1_hold, s1_valid_q && !advance |=> s1_valid_q, "stage 1 beat lost while stalled")
	`ASSERT_CLK(a_completed_step, s1_valid_q && advance && stage_s1.inc_completed |=> result.completed_total == $past(result.completed_total) + 32'd1, "completed count did not advance on retire")
	`ASSERT_NEVER(a_retire_level, out_valid_q && result.retired_valid && result.pending_entries >= CNT_W'(RING_DEPTH), "ring still full after a retire")

endmodule

// ----- hdl/pqr_ctrl.sv -----
// Control stage of the ring: head, fill count, open interval and drop marker.
// Decides each command and registers the decision into stage 1. Uses pqr_pkg.
module pqr_ctrl import pqr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cmd_item_t           item,
	input  logic                timing_enabled,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_addr,
	output logic [TAG_W-1:0]    wr_tag,
	output logic [SAMPLE_W-1:0] wr_sample,
	output logic [IDX_W-1:0]    end_addr,
	output logic [IDX_W-1:0]    poll_addr,
	output stage_t              stage_s1
);

	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0] oldest_q, oldest_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             open_q, open_d;
	logic             drop_q, drop_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_slot;
	stage_t           stage_d;

	// Tail slot: oldest + count stays below twice the depth, so one subtract wraps it.
	always_comb begin
		tail_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(RING_DEPTH)) begin
			tail_slot = IDX_W'(tail_sum - SUM_W'(RING_DEPTH));
		end else begin
			tail_slot = IDX_W'(tail_sum);
		end
	end

	always_comb begin
		oldest_d = oldest_q;
		count_d  = count_q;
		open_d   = open_q;
		drop_d   = drop_q;
		slot_d   = slot_q;
		wr_en    = 1'b0;
		stage_d  = '0;
		case (item.command)
			CMD_BEGIN: begin
				if (timing_enabled) begin
					if (open_q || !item.label_present) begin
						stage_d.inc_invalid = 1'b1;
					end else if (count_q >= CNT_W'(RING_DEPTH)) begin
						// Arm the marker so the matching end is swallowed.
						stage_d.inc_dropped = 1'b1;
						open_d = 1'b1;
						drop_d = 1'b1;
					end else begin
						wr_en  = 1'b1;
						slot_d = tail_slot;
						open_d = 1'b1;
						drop_d = 1'b0;
					end
				end
			end
			CMD_END: begin
				if (!open_q) begin
					stage_d.inc_invalid = timing_enabled;
				end else if (drop_q) begin
					open_d = 1'b0;
					drop_d = 1'b0;
				end else begin
					stage_d.tag_check     = item.label_present;
					stage_d.inc_submitted = 1'b1;
					open_d  = 1'b0;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POLL: begin
				if (count_q != '0 && item.oldest_done) begin
					stage_d.inc_completed = 1'b1;
					count_d = count_q - CNT_W'(1);
					if (oldest_q == IDX_W'(RING_DEPTH - 1)) begin
						oldest_d = '0;
					end else begin
						oldest_d = oldest_q + IDX_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		stage_d.check_tag  = item.label_tag;
		stage_d.elapsed_ns = item.elapsed_ns;
		stage_d.pending    = count_d;
		stage_d.open       = open_d;
		wr_en = wr_en & accept;
	end

	assign wr_addr   = tail_slot;
	assign wr_tag    = item.label_tag;
	assign wr_sample = item.sample_number;
	assign end_addr  = slot_q;
	assign poll_addr = oldest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			open_q   <= 1'b0;
			drop_q   <= 1'b0;
			slot_q   <= '0;
		end else if (accept) begin
			oldest_q <= oldest_d;
			count_q  <= count_d;
			open_q   <= open_d;
			drop_q   <= drop_d;
			slot_q   <= slot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

endmodule

// ----- hdl/pqr_ring_mem.sv -----
// Ring storage: tag and sample number of each slot, one write port,
// registered reads at the open slot and at the oldest slot. Uses pqr_pkg.
module pqr_ring_mem import pqr_pkg::*; (
	input  logic                clk,
	input  logic                rd_en,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic [TAG_W-1:0]    wr_tag,
	input  logic [SAMPLE_W-1:0] wr_sample,
	input  logic [IDX_W-1:0]    end_addr,
	input  logic [IDX_W-1:0]    poll_addr,
	output logic [TAG_W-1:0]    end_tag_s1,
	output logic [TAG_W-1:0]    poll_tag_s1,
	output logic [SAMPLE_W-1:0] poll_sample_s1
);

	logic [TAG_W-1:0]    tag_mem    [RING_DEPTH];
	logic [SAMPLE_W-1:0] sample_mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_addr]    <= wr_tag;
			sample_mem[wr_addr] <= wr_sample;
		end
	end

	// Hold read data while stage 1 is stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			end_tag_s1     <= tag_mem[end_addr];
			poll_tag_s1    <= tag_mem[poll_addr];
			poll_sample_s1 <= sample_mem[poll_addr];
		end
	end

endmodule

// ----- hdl/pqr_stats.sv -----
// Stats stage: tag compare, the four wrapping counters and the result register.
// Uses pqr_pkg.
module pqr_stats import pqr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  stage_t              stage_s1,
	input  logic [TAG_W-1:0]    end_tag_s1,
	input  logic [TAG_W-1:0]    poll_tag_s1,
	input  logic [SAMPLE_W-1:0] poll_sample_s1,
	output res_item_t           result
);

	logic [STAT_W-1:0]   invalid_q, dropped_q, submitted_q, completed_q;
	logic                ret_valid_s2;
	logic [TAG_W-1:0]    ret_tag_s2;
	logic [SAMPLE_W-1:0] ret_sample_s2;
	logic [NS_W-1:0]     ret_ns_s2;
	logic [CNT_W-1:0]    pending_s2;
	logic                open_s2;
	logic                mismatch;

	assign mismatch = stage_s1.tag_check && (end_tag_s1 != stage_s1.check_tag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_q   <= '0;
			dropped_q   <= '0;
			submitted_q <= '0;
			completed_q <= '0;
		end else if (advance) begin
			invalid_q   <= invalid_q + STAT_W'(stage_s1.inc_invalid | mismatch);
			dropped_q   <= dropped_q + STAT_W'(stage_s1.inc_dropped);
			submitted_q <= submitted_q + STAT_W'(stage_s1.inc_submitted);
			completed_q <= completed_q + STAT_W'(stage_s1.inc_completed);
		end
	end

	// Zero the retired fields unless a poll retired an entry.
	always_ff @(posedge clk) begin
		if (advance) begin
			ret_valid_s2  <= stage_s1.inc_completed;
			ret_tag_s2    <= stage_s1.inc_completed ? poll_tag_s1 : '0;
			ret_sample_s2 <= stage_s1.inc_completed ? poll_sample_s1 : '0;
			ret_ns_s2     <= stage_s1.inc_completed ? stage_s1.elapsed_ns : '0;
			pending_s2    <= stage_s1.pending;
			open_s2       <= stage_s1.open;
		end
	end

	always_comb begin
		result.retired_valid   = ret_valid_s2;
		result.retired_tag     = ret_tag_s2;
		result.retired_sample  = ret_sample_s2;
		result.retired_ns      = ret_ns_s2;
		result.pending_entries = pending_s2;
		result.interval_open   = open_s2;
		result.invalid_total   = invalid_q;
		result.dropped_total   = dropped_q;
		result.submitted_total = submitted_q;
		result.completed_total = completed_q;
	end

endmodule
